// File: src/sdf_pkg.sv
// shared constants and types of the stream duplicate filter
// used by sdf_engine and stream_duplicate_filter; no dependencies
package sdf_pkg;

  localparam int unsigned SeenCapacity = 256;
  localparam int unsigned ValW         = 32;
  localparam int unsigned CntW         = $clog2(SeenCapacity + 1);
  localparam int unsigned AddrW        = (SeenCapacity > 1) ? $clog2(SeenCapacity) : 1;

  // one finished result offered by the engine
  typedef struct packed {
    logic            valid;
    logic [ValW-1:0] value;
    logic            not_recorded;
  } res_t;

endpackage

// File: src/stream_duplicate_filter.sv
// stream duplicate filter: drops values already seen in the current list
// Channels: a slave stream carries one request per item, tdata = item_value,
// tuser = first_of_list (empties the seen table before the item is handled).
// The master stream carries one result per new value, tdata = unique_value,
// tuser = not_recorded (table full, value passed on but not stored).
// A duplicate gives no result. Each item walks the sorted table held in one
// ram with a registered read, one entry per cycle, inserting and shifting the
// tail in the same pass; a duplicate ends the walk where it is found. One item
// is handled at a time; the next request is taken once the walk is done and
// its result, if any, is handed on, while the previous result may still sit
// in the output register. Reset empties the table at once (count to zero, no
// clearing pass). When the receiver stalls the finished result waits and the
// walk of the following item holds at its end until the output register is
// free.
// depends on sdf_pkg and sdf_engine
module stream_duplicate_filter (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [sdf_pkg::ValW-1:0] s_axis_tdata,  // [31:0] item_value
  input  logic                     s_axis_tuser,  // [0] first_of_list
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [sdf_pkg::ValW-1:0] m_axis_tdata,  // [31:0] unique_value
  output logic                     m_axis_tuser   // [0] not_recorded
);
  import sdf_pkg::*;

  logic            idle;
  logic            start;
  logic            out_free;
  res_t            res;
  logic            out_valid_q, out_valid_d;
  logic [ValW-1:0] out_data_q, out_data_d;
  logic            out_nrec_q, out_nrec_d;

  assign s_axis_tready = idle;
  assign start         = s_axis_tvalid && idle;
  assign out_free      = !out_valid_q || m_axis_tready;

  sdf_engine u_engine (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .value_i  (s_axis_tdata),
    .first_i  (s_axis_tuser),
    .idle_o   (idle),
    .res_o    (res),
    .res_ack_i(out_free)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_nrec_d  = out_nrec_q;
    priority if (res.valid && out_free) begin
      out_valid_d = 1'b1;
      out_data_d  = res.value;
      out_nrec_d  = res.not_recorded;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    out_nrec_q <= out_nrec_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_nrec_q;

endmodule

// File: src/sdf_ram.sv
// generic simple dual port ram: one write port, one registered read port
// no dependencies
module sdf_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] waddr_i,
  input  logic [Width-1:0]                 wdata_i,
  input  logic                             re_i,
  input  logic [$clog2(Depth > 1 ? Depth : 2)-1:0] raddr_i,
  output logic [Width-1:0]                 rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: src/sdf_engine.sv
// sorted table walk: search, insert and shift through one ram
// depends on sdf_pkg and sdf_ram
module sdf_engine (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [sdf_pkg::ValW-1:0]  value_i,
  input  logic                      first_i,
  output logic                      idle_o,
  output sdf_pkg::res_t             res_o,
  input  logic                      res_ack_i
);
  import sdf_pkg::*;

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StScan = 2'd1;
  localparam logic [1:0] StDone = 2'd2;

  localparam logic [CntW-1:0] Cap = CntW'(SeenCapacity);

  logic [1:0]      state_q, state_d;
  logic [CntW-1:0] count_q, count_d;
  logic [CntW-1:0] n_q, n_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AddrW-1:0] chk_q, chk_d;
  logic            rdv_q, rdv_d;
  logic            ins_q, ins_d;
  logic            nrec_q, nrec_d;
  logic [ValW-1:0] val_q, val_d;
  logic [ValW-1:0] hold_q, hold_d;

  logic             full;
  logic             rd_en;
  logic [ValW-1:0]  rd_data;
  logic             wr_en;
  logic [AddrW-1:0] wr_addr;
  logic [ValW-1:0]  wr_data;

  assign full  = (n_q == Cap);
  assign rd_en = (state_q == StScan) && (cnt_q < n_q);

  sdf_ram #(
    .Width(ValW),
    .Depth(SeenCapacity)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (wr_en),
    .waddr_i(wr_addr),
    .wdata_i(wr_data),
    .re_i   (rd_en),
    .raddr_i(cnt_q[AddrW-1:0]),
    .rdata_o(rd_data)
  );

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    n_d     = n_q;
    cnt_d   = cnt_q;
    chk_d   = chk_q;
    rdv_d   = 1'b0;
    ins_d   = ins_q;
    nrec_d  = nrec_q;
    val_d   = val_q;
    hold_d  = hold_q;
    wr_en   = 1'b0;
    wr_addr = chk_q;
    wr_data = val_q;

    unique case (state_q)
      StIdle: begin
        if (start_i) begin
          n_d     = first_i ? '0 : count_q;
          count_d = n_d;
          val_d   = value_i;
          cnt_d   = '0;
          ins_d   = 1'b0;
          nrec_d  = 1'b0;
          state_d = StScan;
        end
      end
      StScan: begin
        // read issue runs one entry ahead of the check
        if (rd_en) begin
          rdv_d = 1'b1;
          chk_d = cnt_q[AddrW-1:0];
          cnt_d = cnt_q + 1'b1;
        end
        if (rdv_q) begin
          if (!ins_q) begin
            if (rd_data == val_q) begin
              // duplicate: drop it, table untouched
              rdv_d   = 1'b0;
              state_d = StIdle;
            end else if ($signed(rd_data) > $signed(val_q)) begin
              if (full) begin
                nrec_d  = 1'b1;
                rdv_d   = 1'b0;
                state_d = StDone;
              end else begin
                wr_en  = 1'b1;
                hold_d = rd_data;
                ins_d  = 1'b1;
              end
            end
          end else begin
            // shift the tail up by one
            wr_en   = 1'b1;
            wr_data = hold_q;
            hold_d  = rd_data;
          end
        end else if (cnt_q == n_q) begin
          if (full) begin
            nrec_d = 1'b1;
          end else begin
            wr_en   = 1'b1;
            wr_addr = n_q[AddrW-1:0];
            wr_data = ins_q ? hold_q : val_q;
            count_d = n_q + 1'b1;
          end
          state_d = StDone;
        end
      end
      StDone: begin
        if (res_ack_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      count_q <= '0;
      rdv_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      rdv_q   <= rdv_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q    <= n_d;
    cnt_q  <= cnt_d;
    chk_q  <= chk_d;
    ins_q  <= ins_d;
    nrec_q <= nrec_d;
    val_q  <= val_d;
    hold_q <= hold_d;
  end

  assign idle_o             = (state_q == StIdle);
  assign res_o.valid        = (state_q == StDone);
  assign res_o.value        = val_q;
  assign res_o.not_recorded = nrec_q;

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= Cap)
    else $error("seen count above capacity");

  a_no_write_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> !full)
    else $error("table written while full");

  a_read_from_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rdv_q |-> $past(state_q == StScan))
    else $error("read data pending outside a scan");

  a_done_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone && $past(state_q) != StDone) |-> $past(state_q == StScan))
    else $error("result raised without a scan");

endmodule
